### src/etsb_pkg.sv
// Shared types, field widths and constants of the edge timestamp sampler.
package etsb_pkg;

    // Default depth of the sample store in bytes.
    localparam int STORE_BYTES_DEF = 65536;

    // Field widths of the stream words.
    localparam int TS_W        = 32;
    localparam int RADDR_W     = 16;
    localparam int PERIOD_W    = 16;
    localparam int TBYTES_W    = 17;
    localparam int LBITS_W     = 4;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    // Sample period after reset, in ticks.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd79;

    // Divider: quotient bits resolved per cycle and the resulting iteration count.
    localparam int DIV_STEPS = 2;
    localparam int DIV_ITERS = TS_W / DIV_STEPS;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_EDGE  = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    // One decoded input word as it waits for the back end.
    typedef struct packed {
        t_action              action;
        logic                 level;
        logic [TS_W-1:0]      timestamp;
        logic [RADDR_W-1:0]   read_address;
        logic                 read_ok;
    } t_cmd;

    // One result word.
    typedef struct packed {
        t_status              status;
        logic                 recording;
        logic [TBYTES_W-1:0]  byte_count;
        logic [LBITS_W-1:0]   tail_bits;
        logic [7:0]           read_data;
    } t_result;

endpackage

### src/etsb_front.sv
// Front end: unpacks input words, classifies reads and queues commands.
module etsb_front
    import etsb_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    input  logic [1:0]            i_tuser,
    output logic                  o_cmd_valid,
    output t_cmd                  o_cmd,
    input  logic                  i_cmd_pop
);

    localparam int QDEPTH = 2;

    t_cmd        r_q [QDEPTH];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_cnt;
    t_cmd        w_cmd;
    logic        w_push;
    logic [31:0] w_addr_ext;

    // Decode the word and mark reads that fall inside the store.
    always_comb begin
        w_cmd.action       = t_action'(i_tuser);
        w_cmd.level        = i_tdata[0];
        w_cmd.timestamp    = i_tdata[TS_W:1];
        w_cmd.read_address = i_tdata[TS_W+RADDR_W:TS_W+1];
        w_addr_ext         = 32'(w_cmd.read_address);
        w_cmd.read_ok      = (w_addr_ext < 32'(STORE_BYTES));
    end

    assign o_ready     = (r_cnt != 2'(QDEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    // Two-entry command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wptr] <= w_cmd;
                r_wptr      <= ~r_wptr;
            end
            if (i_cmd_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (w_push && !i_cmd_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && i_cmd_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

### src/etsb_div.sv
// Iterative unsigned divider for elapsed ticks over the sample period.
module etsb_div
    import etsb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [TS_W-1:0]     i_num,
    input  logic [PERIOD_W-1:0] i_den,
    output logic                o_done,
    output logic [TS_W-1:0]     o_quo
);

    localparam int CNT_W = $clog2(DIV_ITERS);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_den;
    logic [TS_W-1:0]     r_quo;
    logic [PERIOD_W-1:0] w_rem;
    logic [TS_W-1:0]     w_quo;
    logic [PERIOD_W:0]   w_trial;

    // DIV_STEPS restoring steps per cycle; the dividend shifts out as quotient bits shift in.
    always_comb begin
        w_rem   = r_rem;
        w_quo   = r_quo;
        w_trial = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            w_trial = {w_rem, w_quo[TS_W-1]};
            w_quo   = {w_quo[TS_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                w_trial  = w_trial - {1'b0, r_den};
                w_quo[0] = 1'b1;
            end
            w_rem = w_trial[PERIOD_W-1:0];
        end
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_quo <= w_quo;
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_ITERS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### src/etsb_back.sv
// Back end: recording state, sample packing, byte store and result register.
module etsb_back
    import etsb_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_result             o_out
);

    localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int BI_W   = $clog2(STORE_BYTES + 1);
    localparam int BITS_W = BI_W + 3;
    localparam logic [BITS_W-1:0] CAP_BITS = BITS_W'(STORE_BYTES) << 3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FILL,
        S_READ
    } t_state;

    t_state              r_state;
    logic                r_active;
    logic                r_first;
    logic                r_held;
    logic [TS_W-1:0]     r_last_time;
    logic [BI_W-1:0]     r_byte_idx;
    logic [2:0]          r_bit_idx;
    logic [7:0]          r_cur_byte;
    logic [BITS_W-1:0]   r_left;
    logic                r_stop_after;
    logic [TS_W-1:0]     r_new_ts;
    logic                r_new_lvl;
    logic                r_out_valid;
    t_result             r_out;
    logic [7:0]          r_store [STORE_BYTES];
    logic [7:0]          r_mem_q;

    logic                w_pop;
    logic                w_div_start;
    logic                w_div_done;
    logic [TS_W-1:0]     w_quo;
    logic [PERIOD_W-1:0] w_den;
    logic [BITS_W-1:0]   w_used;
    logic [BITS_W-1:0]   w_room;
    logic                w_empty;
    logic [31:0]         w_tbytes;
    logic [LBITS_W-1:0]  w_tail;
    logic [31:0]         w_addr_ext;
    logic                w_addr_lt;
    logic                w_addr_eq;
    logic                w_whole_byte;
    logic [7:0]          w_set_byte;
    logic                w_mem_we;
    logic [7:0]          w_mem_wdata;
    logic                w_mem_re;
    logic                w_out_set;

    function automatic t_result res_make(input t_status st, input logic rec,
                                         input logic [TBYTES_W-1:0] count,
                                         input logic [LBITS_W-1:0] tail,
                                         input logic [7:0] rdata);
        t_result res;
        res.status     = st;
        res.recording  = rec;
        res.byte_count = count;
        res.tail_bits  = tail;
        res.read_data  = rdata;
        return res;
    endfunction

    // A command is taken only when the result register is free by the time it finishes.
    assign w_pop = (r_state == S_IDLE) && i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_pop = w_pop;

    assign w_div_start = w_pop && (i_cmd.action == ACT_EDGE) && r_active && !r_first;
    assign w_den       = (i_period == '0) ? PERIOD_W'(1) : i_period;

    etsb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (i_cmd.timestamp - r_last_time),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Fill accounting and stop report.
    assign w_used   = {r_byte_idx, 3'b000} + BITS_W'(3'd7 - r_bit_idx);
    assign w_room   = CAP_BITS - w_used;
    assign w_empty  = (r_byte_idx == '0) && (r_bit_idx == 3'd7);
    assign w_tbytes = 32'(r_byte_idx) + 32'(r_bit_idx != 3'd7);
    assign w_tail   = (r_bit_idx == 3'd7) ? LBITS_W'(8) : LBITS_W'(3'd7 - r_bit_idx);

    // Bytes below the fill count live in memory; the partial byte lives in a register.
    assign w_addr_ext = 32'(i_cmd.read_address);
    assign w_addr_lt  = (w_addr_ext < 32'(r_byte_idx));
    assign w_addr_eq  = (w_addr_ext == 32'(r_byte_idx));
    assign w_mem_re   = w_pop && (i_cmd.action == ACT_READ) && i_cmd.read_ok && w_addr_lt;

    // Sample packing: a whole byte when aligned with at least eight samples left, else one bit.
    assign w_whole_byte = (r_bit_idx == 3'd7) && (r_left >= BITS_W'(8));
    assign w_set_byte   = r_cur_byte | (8'(r_held) << r_bit_idx);
    assign w_mem_we     = (r_state == S_FILL) && (r_left != '0)
                          && (w_whole_byte || (r_bit_idx == 3'd0));
    assign w_mem_wdata  = w_whole_byte ? {8{r_held}} : w_set_byte;

    // A result is due when a command finishes: at once, after the fill, or after a stored read.
    assign w_out_set = (w_pop && !w_div_start && !w_mem_re)
                       || ((r_state == S_FILL) && (r_left == '0))
                       || (r_state == S_READ);

    // Sample store with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_store[r_byte_idx[ADDR_W-1:0]] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_mem_q <= r_store[w_addr_ext[ADDR_W-1:0]];
        end
    end

    // Result valid flag: a new result wins over the hand-off of the old one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_set) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Command sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= 1'b0;
            r_first      <= 1'b1;
            r_held       <= 1'b0;
            r_last_time  <= '0;
            r_byte_idx   <= '0;
            r_bit_idx    <= 3'd7;
            r_cur_byte   <= '0;
            r_left       <= '0;
            r_stop_after <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        unique case (i_cmd.action)
                            ACT_START: begin
                                if (r_active) begin
                                    r_out <= res_make(ST_IGNORED, 1'b1, '0, '0, 8'h00);
                                end else begin
                                    r_byte_idx  <= '0;
                                    r_bit_idx   <= 3'd7;
                                    r_cur_byte  <= '0;
                                    r_held      <= 1'b0;
                                    r_last_time <= '0;
                                    r_first     <= 1'b1;
                                    r_active    <= 1'b1;
                                    r_out       <= res_make(ST_DONE, 1'b1, '0, '0, 8'h00);
                                end
                            end
                            ACT_EDGE: begin
                                if (!r_active) begin
                                    r_out <= res_make(ST_IGNORED, 1'b0, '0, '0, 8'h00);
                                end else if (r_first) begin
                                    r_first     <= 1'b0;
                                    r_last_time <= i_cmd.timestamp;
                                    r_held      <= i_cmd.level;
                                    r_out       <= res_make(ST_DONE, 1'b1, '0, '0, 8'h00);
                                end else begin
                                    r_new_ts  <= i_cmd.timestamp;
                                    r_new_lvl <= i_cmd.level;
                                    r_state   <= S_DIV;
                                end
                            end
                            ACT_STOP: begin
                                if (!r_active) begin
                                    r_out <= res_make(ST_IGNORED, 1'b0, '0, '0, 8'h00);
                                end else begin
                                    r_active <= 1'b0;
                                    if (w_empty) begin
                                        r_out <= res_make(ST_EMPTY, 1'b0, '0, '0, 8'h00);
                                    end else begin
                                        r_out <= res_make(ST_DONE, 1'b0,
                                                          w_tbytes[TBYTES_W-1:0], w_tail,
                                                          8'h00);
                                    end
                                end
                            end
                            ACT_READ: begin
                                if (!i_cmd.read_ok) begin
                                    r_out <= res_make(ST_IGNORED, r_active, '0, '0, 8'h00);
                                end else if (w_addr_lt) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_out <= res_make(ST_DONE, r_active, '0, '0,
                                                      w_addr_eq ? r_cur_byte : 8'h00);
                                end
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    // Clip the sample count to the room left in the store.
                    if (w_div_done) begin
                        if (w_quo > 32'(w_room)) begin
                            r_left       <= w_room;
                            r_stop_after <= 1'b1;
                        end else begin
                            r_left       <= w_quo[BITS_W-1:0];
                            r_stop_after <= 1'b0;
                        end
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (r_left == '0) begin
                        r_state <= S_IDLE;
                        if (r_stop_after) begin
                            r_active <= 1'b0;
                            r_out    <= res_make(ST_DONE, 1'b0, '0, '0, 8'h00);
                        end else begin
                            r_last_time <= r_new_ts;
                            r_held      <= r_new_lvl;
                            r_out       <= res_make(ST_DONE, 1'b1, '0, '0, 8'h00);
                        end
                    end else if (w_whole_byte) begin
                        r_byte_idx <= r_byte_idx + BI_W'(1);
                        r_left     <= r_left - BITS_W'(8);
                    end else begin
                        r_left <= r_left - BITS_W'(1);
                        if (r_bit_idx == 3'd0) begin
                            r_cur_byte <= '0;
                            r_bit_idx  <= 3'd7;
                            r_byte_idx <= r_byte_idx + BI_W'(1);
                        end else begin
                            r_cur_byte <= w_set_byte;
                            r_bit_idx  <= r_bit_idx - 3'd1;
                        end
                    end
                end
                S_READ: begin
                    r_out   <= res_make(ST_DONE, r_active, '0, '0, r_mem_q);
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### src/edge_timestamp_to_sample_bits.sv
// Top level of the edge timestamp to sample bit recorder.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser action; tdata level, timestamp, address
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser status; tdata recording .. read_data
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_data sample period
//
// Start, stop, ignored commands, first edges and reads outside the stored bytes finish at
// once; stored reads wait for the registered memory read port. Any later edge runs the
// divider, which resolves two quotient bits a cycle, then packs one aligned byte of constant
// level or one loose sample bit per step. Reset is synchronous and needs no clearing pass,
// as a fill count marks the written part of the store. Inputs queue two deep ahead of the
// back end; a stalled result port holds the back end after its current item.
module edge_timestamp_to_sample_bits
    import etsb_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // level [0], timestamp [32:1], read_address [48:33], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action [1:0]
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // recording [0], byte_count [17:1], tail_bits [21:18], read_data [29:22]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic [1:0]             m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [PERIOD_W-1:0]    i_cfg_data
);

    logic [PERIOD_W-1:0] r_period;
    logic                w_cmd_valid;
    t_cmd                w_cmd;
    logic                w_cmd_pop;
    t_result             w_res;

    // Sample period register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_period <= i_cfg_data;
        end
    end

    etsb_front #(
        .STORE_BYTES (STORE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    etsb_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_period    (r_period),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_res)
    );

    // Result word packing.
    assign m_axis_tdata = {2'b00, w_res.read_data, w_res.tail_bits,
                           w_res.byte_count, w_res.recording};
    assign m_axis_tuser = w_res.status;

`ifndef SYNTHESIS
    // The back end takes a command only from a filled queue and into a free result slot.
    a_pop_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> (w_cmd_valid && (!m_axis_tvalid || m_axis_tready)))
        else $error("command taken while the result slot is busy");

    // A stop with nothing recorded ends recording and reports no bytes.
    a_empty_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_EMPTY)) |->
        (!w_res.recording && (w_res.byte_count == '0)))
        else $error("empty stop reported bytes or kept recording");

    // A stop report carries a nonzero byte count and one to eight bits in the last byte.
    a_stop_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_res.tail_bits != '0)) |->
        ((w_res.byte_count != '0) && (w_res.tail_bits <= LBITS_W'(8))
         && !w_res.recording && (m_axis_tuser == ST_DONE)))
        else $error("malformed stop report");
`endif

endmodule

### tb/sv/tb_edge_timestamp_to_sample_bits.sv
// Self-checking testbench for the edge timestamp to sample bit recorder.
`timescale 1ns / 1ps

module tb_edge_timestamp_to_sample_bits;
    import etsb_pkg::*;

    localparam int STORE_BYTES     = STORE_BYTES_DEF;
    localparam int STORE_BITS      = STORE_BYTES * 8;
    // The limit leaves room for one edge that fills the whole store with no handshake meanwhile.
    localparam int IDLE_LIMIT      = 300000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int ITEMS_PER_PHASE = 200;

    // Receiver stall patterns.
    localparam int RX_OPEN    = 0;
    localparam int RX_COIN    = 1;
    localparam int RX_QUARTER = 2;
    localparam int RX_LONG    = 3;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    // One line of the directed table; a register row carries its value in addr.
    typedef struct {
        t_row_kind kind;
        t_action   act;
        logic      lvl;
        logic [31:0] ts;
        logic [15:0] addr;
        bit        known;
        t_result   res;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [PERIOD_W-1:0]    i_cfg_data = '0;

    // Shadow of the recorder state, advanced once per accepted input word.
    logic [15:0]  rec_period;
    bit           rec_active;
    bit           await_first;
    bit           hold_lvl;
    logic [31:0]  t_last;
    int unsigned  wr_byte;
    logic [2:0]   wr_bit;
    logic [7:0]   smp_mem [STORE_BYTES];

    t_result      result_q[$];
    t_dir_row     dir_tab[$];
    int unsigned  n_fail = 0;
    int unsigned  words_sent = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  burst_left = 0;
    int unsigned  rx_mode = RX_OPEN;
    int unsigned  rx_cnt = 0;
    int unsigned  rx_hold = 0;

    edge_timestamp_to_sample_bits u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Appends n samples of one level, MSB first, whole bytes at a time where aligned.
    function automatic void store_run(int unsigned n, bit lvl);
        while (n > 0) begin
            if (wr_bit == 3'd7 && n >= 8) begin
                if (lvl) smp_mem[wr_byte] = 8'hFF;
                wr_byte++;
                n -= 8;
            end else begin
                if (lvl) smp_mem[wr_byte][wr_bit] = 1'b1;
                if (wr_bit == 3'd0) begin
                    wr_bit = 3'd7;
                    wr_byte++;
                end else begin
                    wr_bit--;
                end
                n--;
            end
        end
    endfunction

    // Computes the result word of one input word and updates the shadow state.
    function automatic t_result predict_word(t_action act, logic lvl, logic [31:0] ts,
                                             logic [15:0] addr);
        t_result     r;
        int unsigned used;
        int unsigned room;
        int unsigned per;
        int unsigned total;
        logic [31:0] samples;
        r = '0;
        r.status = ST_DONE;
        used = wr_byte * 8 + (7 - int'(wr_bit));
        case (act)
            ACT_START: begin
                if (rec_active) begin
                    r.status = ST_IGNORED;
                end else begin
                    // Only bytes up to the fill point can hold ones.
                    for (int i = 0; i <= int'(wr_byte) && i < STORE_BYTES; i++)
                        smp_mem[i] = '0;
                    wr_byte = 0;
                    wr_bit = 3'd7;
                    hold_lvl = 1'b0;
                    t_last = '0;
                    await_first = 1'b1;
                    rec_active = 1'b1;
                end
            end
            ACT_EDGE: begin
                if (!rec_active) begin
                    r.status = ST_IGNORED;
                end else if (await_first) begin
                    await_first = 1'b0;
                    t_last = ts;
                    hold_lvl = lvl;
                end else begin
                    per = (rec_period == 0) ? 1 : rec_period;
                    samples = (ts - t_last) / per;
                    room = STORE_BITS - used;
                    if (samples > room) begin
                        // The store runs full: keep what fits and stop.
                        store_run(room, hold_lvl);
                        rec_active = 1'b0;
                    end else begin
                        store_run(samples, hold_lvl);
                        t_last = ts;
                        hold_lvl = lvl;
                    end
                end
            end
            ACT_STOP: begin
                if (!rec_active) begin
                    r.status = ST_IGNORED;
                end else begin
                    total = used;
                    rec_active = 1'b0;
                    if (total == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.byte_count = 17'((total + 7) / 8);
                        r.tail_bits = 4'((total % 8 == 0) ? 8 : total % 8);
                    end
                end
            end
            default: begin
                if (int'(addr) < STORE_BYTES) r.read_data = smp_mem[addr];
                else r.status = ST_IGNORED;
            end
        endcase
        r.recording = rec_active;
        return r;
    endfunction

    function automatic t_dir_row item_row(t_action act, logic lvl, logic [31:0] ts,
                                          logic [15:0] addr);
        t_dir_row row;
        row = '{ROW_ITEM, act, lvl, ts, addr, 1'b0, '0};
        return row;
    endfunction

    function automatic t_dir_row known_row(t_action act, logic lvl, logic [31:0] ts,
                                           logic [15:0] addr, t_status st, logic rec,
                                           logic [16:0] tb, logic [3:0] lb, logic [7:0] rd);
        t_dir_row row;
        row = '{ROW_ITEM, act, lvl, ts, addr, 1'b1, '0};
        row.res.status = st;
        row.res.recording = rec;
        row.res.byte_count = tb;
        row.res.tail_bits = lb;
        row.res.read_data = rd;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(logic [15:0] value);
        t_dir_row row;
        row = '{ROW_CFG, ACT_START, 1'b0, '0, value, 1'b0, '0};
        return row;
    endfunction

    function automatic logic [15:0] pick_read_addr();
        return 16'($urandom_range(0, (wr_byte < STORE_BYTES) ? wr_byte : STORE_BYTES - 1));
    endfunction

    // Sends one word in bursts with random gaps; the expectation is queued on acceptance.
    task automatic push_word(t_action act, logic lvl, logic [31:0] ts, logic [15:0] addr,
                             bit known, t_result known_res);
        t_result     pred;
        int unsigned gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {7'd0, addr, ts, lvl};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_word(act, lvl, ts, addr);
        result_q.push_back(known ? known_res : pred);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // Holds the sender off until every expected result word has come back.
    task automatic wait_results_in();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    // Writes the sample period while the block is idle.
    task automatic write_period(logic [15:0] value);
        wait_results_in();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        rec_period = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A well-formed recording: start, first edge, a run of edges, mostly a stop, some reads.
    task automatic record_sequence();
        logic [31:0] stamp;
        logic        lvl;
        int unsigned per_eff;
        int unsigned k;
        if (rec_active)
            push_word(ACT_STOP, 1'($urandom), $urandom, 16'($urandom), 1'b0, '0);
        push_word(ACT_START, 1'($urandom), $urandom, 16'($urandom), 1'b0, '0);
        stamp = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4000)
                                            : $urandom;
        lvl = 1'($urandom_range(0, 1));
        push_word(ACT_EDGE, lvl, stamp, 16'($urandom), 1'b0, '0);
        per_eff = (rec_period == 0) ? 1 : rec_period;
        repeat ($urandom_range(1, 30)) begin
            k = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
            stamp = stamp + per_eff * k + $urandom_range(0, per_eff - 1);
            if ($urandom_range(0, 3) != 0) lvl = ~lvl;
            push_word(ACT_EDGE, lvl, stamp, 16'($urandom), 1'b0, '0);
            if ($urandom_range(0, 5) == 0)
                push_word(ACT_READ, 1'($urandom), $urandom, pick_read_addr(), 1'b0, '0);
        end
        if ($urandom_range(0, 9) != 0)
            push_word(ACT_STOP, 1'($urandom), $urandom, 16'($urandom), 1'b0, '0);
        repeat ($urandom_range(0, 3))
            push_word(ACT_READ, 1'($urandom), $urandom, pick_read_addr(), 1'b0, '0);
        if ($urandom_range(0, 19) == 0) wait_results_in();
    endtask

    // Receiver: ready follows a stall pattern picked anew at random whenever its hold count runs out.
    always @(negedge i_clk) begin
        if (rx_cnt == 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_LONG);
            rx_cnt = $urandom_range(50, 400);
        end else begin
            rx_cnt--;
        end
        case (rx_mode)
            RX_OPEN:    m_axis_tready <= 1'b1;
            RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
            RX_QUARTER: m_axis_tready <= (rx_cnt % 4 == 0);
            default: begin
                if (rx_hold == 0) begin
                    m_axis_tready <= ~m_axis_tready;
                    rx_hold = $urandom_range(1, 20);
                end else begin
                    rx_hold--;
                end
            end
        endcase
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    // Compare each result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                $error("result word with no expectation waiting");
                n_fail++;
            end else begin
                want = result_q.pop_front();
                check_field("status", want.status, m_axis_tuser);
                check_field("recording", want.recording, m_axis_tdata[0]);
                check_field("byte_count", want.byte_count, m_axis_tdata[17:1]);
                check_field("tail_bits", want.tail_bits, m_axis_tdata[21:18]);
                check_field("read_data", want.read_data, m_axis_tdata[29:22]);
            end
        end
    end

    // Watchdog on cycles in which no handshake completes.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[edge_timestamp_to_sample_bits] ERROR");
            $finish;
        end
    end

    initial begin
        logic [15:0] phase_periods[$];
        int unsigned phase_start;
        rec_period = PERIOD_RESET;
        rec_active = 1'b0;
        await_first = 1'b1;
        hold_lvl = 1'b0;
        t_last = '0;
        wr_byte = 0;
        wr_bit = 3'd7;
        foreach (smp_mem[i]) smp_mem[i] = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Idle cases, double start, empty stop and a wrapping timestamp at the reset period.
        dir_tab.push_back(known_row(ACT_STOP, 0, 0, 0, ST_IGNORED, 0, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_EDGE, 1, 32'hFFFF_FFFF, 0, ST_IGNORED, 0, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_READ, 0, 0, 0, ST_DONE, 0, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_START, 0, 0, 0, ST_DONE, 1, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_START, 1, 0, 0, ST_IGNORED, 1, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_STOP, 0, 0, 0, ST_EMPTY, 0, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_START, 0, 0, 0, ST_DONE, 1, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_EDGE, 1, 32'hFFFF_FF00, 0, ST_DONE, 1, 0, 0, 0));
        dir_tab.push_back(item_row(ACT_EDGE, 0, 32'h0000_0200, 16'hFFFF));
        dir_tab.push_back(item_row(ACT_EDGE, 1, 32'd1776, 0));
        dir_tab.push_back(item_row(ACT_EDGE, 0, 32'd2012, 0));
        dir_tab.push_back(item_row(ACT_STOP, 0, 0, 0));
        dir_tab.push_back(item_row(ACT_READ, 0, 0, 16'd1));
        // Exact fill keeps recording on; the next edge with a sample stops it.
        dir_tab.push_back(cfg_row(16'd1));
        dir_tab.push_back(known_row(ACT_START, 0, 0, 0, ST_DONE, 1, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_EDGE, 1, 0, 0, ST_DONE, 1, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_EDGE, 0, STORE_BITS, 0, ST_DONE, 1, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_EDGE, 1, STORE_BITS + 1, 0, ST_DONE, 0, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_READ, 0, 0, 16'hFFFF, ST_DONE, 0, 0, 0, 8'hFF));
        // Exact fill followed by a stop reports a full store.
        dir_tab.push_back(known_row(ACT_START, 0, 0, 0, ST_DONE, 1, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_EDGE, 1, 0, 0, ST_DONE, 1, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_EDGE, 0, STORE_BITS, 0, ST_DONE, 1, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_STOP, 0, 0, 0, ST_DONE, 0, STORE_BYTES, 8, 0));
        // An edge that overflows the store partway through.
        dir_tab.push_back(known_row(ACT_START, 0, 0, 0, ST_DONE, 1, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_EDGE, 0, 32'd100, 0, ST_DONE, 1, 0, 0, 0));
        dir_tab.push_back(item_row(ACT_EDGE, 1, 32'd103, 0));
        dir_tab.push_back(item_row(ACT_EDGE, 0, 32'hFFFF_FFFF, 0));
        dir_tab.push_back(item_row(ACT_READ, 0, 0, 0));
        // A zero period counts as one tick per sample.
        dir_tab.push_back(cfg_row(16'd0));
        dir_tab.push_back(known_row(ACT_START, 0, 0, 0, ST_DONE, 1, 0, 0, 0));
        dir_tab.push_back(known_row(ACT_EDGE, 1, 32'd10, 0, ST_DONE, 1, 0, 0, 0));
        dir_tab.push_back(item_row(ACT_EDGE, 0, 32'd13, 0));
        dir_tab.push_back(item_row(ACT_STOP, 0, 0, 0));

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG)
                write_period(dir_tab[i].addr);
            else
                push_word(dir_tab[i].act, dir_tab[i].lvl, dir_tab[i].ts, dir_tab[i].addr,
                          dir_tab[i].known, dir_tab[i].res);
        end
        wait_results_in();

        // Random part: one phase per sample period, extremes included.
        phase_periods = '{16'hFFFF, PERIOD_RESET, 16'd1, 16'd0,
                          16'($urandom_range(2, 400)), 16'($urandom_range(401, 65534))};
        foreach (phase_periods[p]) begin
            write_period(phase_periods[p]);
            phase_start = words_sent;
            while (words_sent - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 80)
                    record_sequence();
                else
                    push_word(t_action'($urandom_range(0, 3)), 1'($urandom), $urandom,
                              16'($urandom), 1'b0, '0);
            end
        end

        wait_results_in();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("[edge_timestamp_to_sample_bits] OK");
        else
            $display("[edge_timestamp_to_sample_bits] ERROR");
        $finish;
    end

endmodule
